@@ rtl/core/ogbd_pkg.sv @@
// Shared types, constants and codes for the occupancy grid downsampler.
package ogbd_pkg;

   // Default sizing of the line store and of the block registers
   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_MAX_BLOCK = 64;

   // Fixed field widths
   localparam int VALUE_W    = 8;
   localparam int ROW_W      = 11;
   localparam int COL_OUT_W  = 11;
   localparam int SUM_W      = 21;
   localparam int GRID_CFG_W = 12;
   localparam int BLK_CFG_W  = 7;
   localparam int GH_W       = 12;
   localparam int ROW_LIMIT  = 2048;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Occupancy codes
   localparam int OCC_VALUE  = 100;
   localparam int UNK_LIMIT  = 10;
   localparam int UNK_VALUE  = -1;

   typedef enum logic [1:0] {
      REG_GRID_WIDTH   = 2'd0,
      REG_GRID_HEIGHT  = 2'd1,
      REG_BLOCK_WIDTH  = 2'd2,
      REG_BLOCK_HEIGHT = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MERGE,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [GRID_CFG_W-1:0] grid_width;
      logic [GRID_CFG_W-1:0] grid_height;
      logic [BLK_CFG_W-1:0]  block_width;
      logic [BLK_CFG_W-1:0]  block_height;
   } cfg_type;

   // One line store entry: partial block sum and its flags
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             unk;
      logic             occ;
   } mem_word_type;

   typedef struct packed {
      logic init;
      logic clear_step;
      logic accept;
      logic merge;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic hit;
      logic job_close;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/ogbd_req_if.sv @@
// Input channel carrying fine occupancy cells.
interface ogbd_req_if import ogbd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] fine_value;

   modport source (output valid, output fine_value, input ready);
   modport sink   (input valid, input fine_value, output ready);
endinterface

@@ rtl/core/ogbd_rsp_if.sv @@
// Result channel carrying coarse occupancy cells.
interface ogbd_rsp_if import ogbd_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [VALUE_W-1:0]   coarse_value;
   logic        [ROW_W-1:0]     lower_fine_row;
   logic        [COL_OUT_W-1:0] right_fine_col;
   logic                        frame_done;

   modport source (output valid, output coarse_value, output lower_fine_row,
                   output right_fine_col, output frame_done, input ready);
   modport sink   (input valid, input coarse_value, input lower_fine_row,
                   input right_fine_col, input frame_done, output ready);
endinterface

@@ rtl/core/occupancy_grid_block_downsampler.sv @@
// Top level of the occupancy grid block downsampler.
//
//   channel   direction  handshake            payload
//   req_chan  in         valid / ready        fine_value
//   rsp_chan  out        valid / ready        coarse_value, lower_fine_row,
//                                             right_fine_col, frame_done
//   csr (APB) in         psel/penable/pready  grid_width, grid_height,
//                                             block_width, block_height
//
// A cell that does not end a block segment is only accepted. A cell that
// ends a segment inside the row also goes through a line store read and a
// merge. A cell that closes a coarse cell then waits for the bit-serial
// divider (21 steps) and for the emit. Reset is synchronous; after reset and
// after every register write a clearing pass wipes the line store and finds
// the row phase; no cell is taken meanwhile.
// A stalled result sits in the output register; an emit waits only if it is
// still occupied.
module occupancy_grid_block_downsampler import ogbd_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
   input  logic                  clock,
   input  logic                  reset,
   ogbd_req_if.sink              req_chan,
   ogbd_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_index;
   logic          cfg_write;
   logic          req_ready;
   cmd_type       cmd;
   status_type    status;

   // Register file: one word per register, written in the APB access phase.
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[3:2]);
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index)
            REG_GRID_WIDTH:   cfg_in.grid_width   = pwdata[GRID_CFG_W-1:0];
            REG_GRID_HEIGHT:  cfg_in.grid_height  = pwdata[GRID_CFG_W-1:0];
            REG_BLOCK_WIDTH:  cfg_in.block_width  = pwdata[BLK_CFG_W-1:0];
            REG_BLOCK_HEIGHT: cfg_in.block_height = pwdata[BLK_CFG_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Read back the raw register values, zero extended.
   always_comb begin
      case (reg_index)
         REG_GRID_WIDTH:   prdata = CSR_DATA_W'(cfg_ff.grid_width);
         REG_GRID_HEIGHT:  prdata = CSR_DATA_W'(cfg_ff.grid_height);
         REG_BLOCK_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.block_width);
         REG_BLOCK_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.block_height);
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width   <= GRID_CFG_W'(2048);
         cfg_ff.grid_height  <= GRID_CFG_W'(2048);
         cfg_ff.block_width  <= BLK_CFG_W'(1);
         cfg_ff.block_height <= BLK_CFG_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The controller owns the input handshake; the datapath owns the result
   // register and answers the output handshake on its own.
   assign req_chan.ready = req_ready;

   ogbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (cfg_write),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ogbd_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .status     (status),
      .fine_value (req_chan.fine_value),
      .rsp_chan   (rsp_chan)
   );

endmodule

@@ rtl/core/ogbd_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ogbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ogbd_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module ogbd_div #(
   parameter int DVD_W = 21,
   parameter int DVS_W = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the trial difference when it does not go negative
         if (!trial[DVS_W]) begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/ogbd_dp.sv @@
// Datapath: raster counters, line store, block averaging and result register.
module ogbd_dp import ogbd_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic signed [VALUE_W-1:0] fine_value,
   ogbd_rsp_if.source                rsp_chan
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int GW_W  = $clog2(MAX_WIDTH + 1);
   localparam int BLK_W = $clog2(MAX_BLOCK + 1);
   localparam int SUB_W = $clog2(MAX_BLOCK);
   localparam int EXT_W = ((GW_W > BLK_W) ? GW_W : BLK_W) + 2;
   localparam int DIV_W = 2 * BLK_W;
   localparam int AVG_W = SUM_W + 1;
   localparam logic signed [AVG_W-1:0] VAL_MAX = AVG_W'(2 ** (VALUE_W - 1) - 1);
   localparam logic signed [AVG_W-1:0] VAL_MIN = AVG_W'(-(2 ** (VALUE_W - 1)));

   // effective register values
   logic [GW_W-1:0]  gw_eff;
   logic [GH_W-1:0]  gh_eff;
   logic [BLK_W-1:0] bw_eff;
   logic [BLK_W-1:0] bh_eff;

   // raster position
   logic [COL_W-1:0] col_ff, col_in;
   logic [SUB_W-1:0] sub_ff, sub_in;
   logic [COL_W-1:0] bstart_ff, bstart_in;
   logic [COL_W-1:0] blk_ff, blk_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] rmod_ff, rmod_in;
   logic [ROW_W-1:0] rtop_ff, rtop_in;
   logic [COL_W-1:0] clr_ff, clr_in;

   // running block-row segment
   logic [SUM_W-1:0] run_sum_ff, run_sum_in;
   logic             run_unk_ff, run_unk_in;
   logic             run_occ_ff, run_occ_in;

   // cell in flight
   logic [COL_W-1:0] job_blk_ff, job_blk_in;
   logic [ROW_W-1:0] job_row_ff, job_row_in;
   logic [COL_W-1:0] job_col_ff, job_col_in;
   logic             job_close_ff, job_close_in;
   logic             job_last_ff, job_last_in;
   logic             job_neg_ff, job_neg_in;
   logic             job_unk_ff, job_unk_in;
   logic             job_occ_ff, job_occ_in;

   logic [DIV_W-1:0] divisor_ff, divisor_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ROW_W-1:0]          rsp_row_ff, rsp_row_in;
   logic [COL_OUT_W-1:0]      rsp_col_ff, rsp_col_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic             in_range;
   logic             block_end;
   logic             col_last;
   logic             next_fits;
   logic [SUM_W-1:0] value_ext;
   mem_word_type     rd_word;
   mem_word_type     wr_word;
   logic             wr_en;
   logic [COL_W-1:0] wr_addr;
   logic [SUM_W-1:0] merged_sum;
   logic [SUM_W-1:0] merged_mag;
   logic             div_start;
   logic             div_done;
   logic [SUM_W-1:0] div_quo;
   logic signed [AVG_W-1:0] avg_raw;
   logic signed [AVG_W-1:0] avg_rule;
   logic signed [AVG_W-1:0] avg_sat;

   // clamp register values into their working ranges
   always_comb begin
      if (cfg.grid_width == '0) begin
         gw_eff = GW_W'(1);
      end else if (32'(cfg.grid_width) > MAX_WIDTH) begin
         gw_eff = GW_W'(MAX_WIDTH);
      end else begin
         gw_eff = GW_W'(cfg.grid_width);
      end
      if (cfg.grid_height == '0) begin
         gh_eff = GH_W'(1);
      end else if (32'(cfg.grid_height) > ROW_LIMIT) begin
         gh_eff = GH_W'(ROW_LIMIT);
      end else begin
         gh_eff = cfg.grid_height;
      end
      if (cfg.block_width == '0) begin
         bw_eff = BLK_W'(1);
      end else if (32'(cfg.block_width) > MAX_BLOCK) begin
         bw_eff = BLK_W'(MAX_BLOCK);
      end else begin
         bw_eff = BLK_W'(cfg.block_width);
      end
      if (cfg.block_height == '0) begin
         bh_eff = BLK_W'(1);
      end else if (32'(cfg.block_height) > MAX_BLOCK) begin
         bh_eff = BLK_W'(MAX_BLOCK);
      end else begin
         bh_eff = BLK_W'(cfg.block_height);
      end
   end

   assign divisor_in = DIV_W'(bw_eff) * DIV_W'(bh_eff);

   // a block counts only when it fits entirely inside the row
   assign in_range  = (EXT_W'(bstart_ff) + EXT_W'(bw_eff)) <= EXT_W'(gw_eff);
   assign next_fits = (EXT_W'(bstart_ff) + EXT_W'(bw_eff) + EXT_W'(bw_eff))
                      <= EXT_W'(gw_eff);
   assign block_end = (EXT_W'(sub_ff) + EXT_W'(1)) == EXT_W'(bw_eff);
   assign col_last  = (EXT_W'(col_ff) + EXT_W'(1)) == EXT_W'(gw_eff);
   assign value_ext = {{(SUM_W - VALUE_W){fine_value[VALUE_W-1]}}, fine_value};

   assign merged_sum = rd_word.sum + run_sum_ff;
   assign merged_mag = merged_sum[SUM_W-1] ? (SUM_W'(0) - merged_sum) : merged_sum;
   assign div_start  = cmd.merge && job_close_ff;

   always_comb begin
      col_in       = col_ff;
      sub_in       = sub_ff;
      bstart_in    = bstart_ff;
      blk_in       = blk_ff;
      row_in       = row_ff;
      rmod_in      = rmod_ff;
      rtop_in      = rtop_ff;
      clr_in       = clr_ff;
      run_sum_in   = run_sum_ff;
      run_unk_in   = run_unk_ff;
      run_occ_in   = run_occ_ff;
      job_blk_in   = job_blk_ff;
      job_row_in   = job_row_ff;
      job_col_in   = job_col_ff;
      job_close_in = job_close_ff;
      job_last_in  = job_last_ff;
      job_neg_in   = job_neg_ff;
      job_unk_in   = job_unk_ff;
      job_occ_in   = job_occ_ff;
      wr_en        = 1'b0;
      wr_addr      = job_blk_ff;
      wr_word      = '0;

      if (cmd.init) begin
         col_in     = '0;
         sub_in     = '0;
         bstart_in  = '0;
         blk_in     = '0;
         row_in     = ROW_W'(gh_eff - GH_W'(1));
         rmod_in    = ROW_W'(gh_eff - GH_W'(1));
         clr_in     = '0;
         run_sum_in = '0;
         run_unk_in = 1'b0;
         run_occ_in = 1'b0;
      end

      if (cmd.clear_step) begin
         // wipe one line store entry and reduce the top row phase
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         if (clr_ff != COL_W'(MAX_WIDTH - 1)) begin
            clr_in = clr_ff + COL_W'(1);
         end
         if (rmod_ff >= ROW_W'(bh_eff)) begin
            rmod_in = rmod_ff - ROW_W'(bh_eff);
         end
         rtop_in = rmod_ff;
      end

      if (cmd.accept) begin
         job_blk_in   = blk_ff;
         job_row_in   = row_ff;
         job_col_in   = col_ff;
         job_close_in = (rmod_ff == '0);
         job_last_in  = (row_ff == '0) && !next_fits;
         if (in_range) begin
            run_sum_in = run_sum_ff + value_ext;
            run_unk_in = run_unk_ff | fine_value[VALUE_W-1];
            run_occ_in = run_occ_ff | (fine_value == VALUE_W'(OCC_VALUE));
         end
         if (col_last) begin
            col_in    = '0;
            sub_in    = '0;
            bstart_in = '0;
            blk_in    = '0;
            if (row_ff == '0) begin
               row_in  = ROW_W'(gh_eff - GH_W'(1));
               rmod_in = rtop_ff;
            end else begin
               row_in  = row_ff - ROW_W'(1);
               rmod_in = (rmod_ff == '0) ? ROW_W'(bh_eff - BLK_W'(1))
                                         : rmod_ff - ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
            if (block_end) begin
               sub_in    = '0;
               bstart_in = bstart_ff + COL_W'(bw_eff);
               blk_in    = blk_ff + COL_W'(1);
            end else begin
               sub_in = sub_ff + SUB_W'(1);
            end
         end
      end

      if (cmd.merge) begin
         // fold the segment into the column store; a closing row empties it
         wr_en      = 1'b1;
         wr_addr    = job_blk_ff;
         run_sum_in = '0;
         run_unk_in = 1'b0;
         run_occ_in = 1'b0;
         job_neg_in = merged_sum[SUM_W-1];
         job_unk_in = rd_word.unk | run_unk_ff;
         job_occ_in = rd_word.occ | run_occ_ff;
         if (!job_close_ff) begin
            wr_word.sum = merged_sum;
            wr_word.unk = rd_word.unk | run_unk_ff;
            wr_word.occ = rd_word.occ | run_occ_ff;
         end
      end
   end

   ogbd_ram #(
      .WIDTH ($bits(mem_word_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_addr (job_blk_ff),
      .rd_data (rd_word)
   );

   ogbd_div #(
      .DVD_W (SUM_W),
      .DVS_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (merged_mag),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // apply sign, unknown and occupied rules, then saturate
   always_comb begin
      avg_raw = job_neg_ff ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});
      avg_rule = avg_raw;
      if (job_unk_ff && (avg_raw < AVG_W'(UNK_LIMIT))) begin
         avg_rule = AVG_W'(UNK_VALUE);
      end
      if (job_occ_ff) begin
         avg_rule = AVG_W'(OCC_VALUE);
      end
      if (avg_rule > VAL_MAX) begin
         avg_sat = VAL_MAX;
      end else if (avg_rule < VAL_MIN) begin
         avg_sat = VAL_MIN;
      end else begin
         avg_sat = avg_rule;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = VALUE_W'(avg_sat);
         rsp_row_in   = job_row_ff;
         rsp_col_in   = COL_OUT_W'(job_col_ff);
         rsp_last_in  = job_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      sub_ff       <= sub_in;
      bstart_ff    <= bstart_in;
      blk_ff       <= blk_in;
      row_ff       <= row_in;
      rmod_ff      <= rmod_in;
      rtop_ff      <= rtop_in;
      clr_ff       <= clr_in;
      run_sum_ff   <= run_sum_in;
      run_unk_ff   <= run_unk_in;
      run_occ_ff   <= run_occ_in;
      job_blk_ff   <= job_blk_in;
      job_row_ff   <= job_row_in;
      job_col_ff   <= job_col_in;
      job_close_ff <= job_close_in;
      job_last_ff  <= job_last_in;
      job_neg_ff   <= job_neg_in;
      job_unk_ff   <= job_unk_in;
      job_occ_ff   <= job_occ_in;
      divisor_ff   <= divisor_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.clear_done = (clr_ff == COL_W'(MAX_WIDTH - 1))
                              && (rmod_ff < ROW_W'(bh_eff));
   assign status.hit        = in_range && block_end;
   assign status.job_close  = job_close_ff;
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.coarse_value   = rsp_value_ff;
   assign rsp_chan.lower_fine_row = rsp_row_ff;
   assign rsp_chan.right_fine_col = rsp_col_ff;
   assign rsp_chan.frame_done     = rsp_last_ff;

endmodule

@@ rtl/core/ogbd_ctrl.sv @@
// Controller: sequences clearing, cell intake, store merge, divide and emit.
module ogbd_ctrl import ogbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cfg_write,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.hit) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = status.job_close ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
      // any register write restarts the frame
      if (cfg_write) begin
         state_in = ST_INIT;
      end
   end

endmodule
